/* hw/rtl/gain_scheduled_steering_pd_defines.svh */
// Assertion macros for the steering PD block.
// GSSP_ASSERT checks a property on the rising clock edge outside reset.
// GSSP_ASSERT_ALWAYS checks a property on every rising clock edge.
`ifndef GAIN_SCHEDULED_STEERING_PD_DEFINES_SVH
`define GAIN_SCHEDULED_STEERING_PD_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define GSSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GSSP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GSSP_ASSERT(lbl, prop, msg)
`define GSSP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* hw/rtl/gssp_pkg.sv */
package gssp_pkg;

  // Field widths
  localparam int ErrW    = 9;
  localparam int VisW    = 8;
  localparam int CornW   = 4;
  localparam int RunW    = 8;
  localparam int SteerW  = 15;
  localparam int GainW   = 17;
  localparam int OffW    = 13;
  localparam int DGainW  = 12;
  localparam int HeightW = 8;
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 15;

  // Shared multiplier operand and product widths
  localparam int MulW  = 18;
  localparam int ProdW = 2 * MulW;
  localparam int AccW  = 28;
  localparam int StW   = AccW - 4;

  // Register indexes of the configuration port
  localparam logic [CfgAddrW-1:0] CFG_SEG_MODE    = 3'd0;
  localparam logic [CfgAddrW-1:0] CFG_GAIN_OFFSET = 3'd1;
  localparam logic [CfgAddrW-1:0] CFG_DERIV_GAIN  = 3'd2;
  localparam logic [CfgAddrW-1:0] CFG_IMG_HEIGHT  = 3'd3;
  localparam logic [CfgAddrW-1:0] CFG_LEFT_LIMIT  = 3'd4;
  localparam logic [CfgAddrW-1:0] CFG_RIGHT_LIMIT = 3'd5;

  // Register reset values
  localparam logic [HeightW-1:0]       HEIGHT_RST = 8'd60;
  localparam logic signed [SteerW-1:0] LEFT_RST   = 15'sd200;
  localparam logic signed [SteerW-1:0] RIGHT_RST  = -15'sd200;

  // Reciprocals for square / 10 and square / 12, both followed by >> RecipShift.
  // Exact for every 16-bit square.
  localparam int RecipShift = 19;
  localparam logic [15:0] RECIP_10 = 16'd52429;
  localparam logic [15:0] RECIP_12 = 16'd43691;

  localparam logic [GainW-1:0] GAIN_MAX = 17'd131071;

  // Base gains in units of 1/16
  localparam logic [9:0] BASE_13   = 10'd208;
  localparam logic [9:0] BASE_16   = 10'd256;
  localparam logic [9:0] BASE_23   = 10'd368;
  localparam logic [9:0] BASE_25   = 10'd400;
  localparam logic [9:0] BASE_26   = 10'd416;
  localparam logic [9:0] BASE_27   = 10'd432;
  localparam logic [9:0] BASE_28   = 10'd448;
  localparam logic [9:0] BASE_33H  = 10'd536;

  // Segmented priority table: first matching row wins
  function automatic logic [9:0] seg_base(input logic [VisW-1:0]  vis,
                                          input logic [CornW-1:0] corners,
                                          input logic             straight,
                                          input logic             crossing,
                                          input logic [RunW-1:0]  run);
    logic [9:0] b;
    if (straight && corners == '0)        b = BASE_16;
    else if (vis > 8'd50 && corners == '0) b = BASE_16;
    else if (crossing)                     b = BASE_13;
    else if (vis >= 8'd48 && corners != '0)
      b = (run > 8'd25) ? BASE_16 : BASE_23;
    else if (vis > 8'd45)                  b = BASE_27;
    else if (vis > 8'd37)                  b = BASE_28;
    else if (vis > 8'd30)                  b = BASE_25;
    else                                   b = BASE_26;
    return b;
  endfunction

  // Fixed-mode base gain
  function automatic logic [9:0] fix_base(input logic [VisW-1:0]  vis,
                                          input logic [CornW-1:0] corners,
                                          input logic             crossing);
    logic [9:0] b;
    if ((vis > 8'd52 && corners == '0) || crossing) b = BASE_16;
    else                                             b = BASE_33H;
    return b;
  endfunction

endpackage

/* hw/rtl/gain_scheduled_steering_pd.sv */
// Gain-scheduled PD steering law.
// Input stream (in_*): one request per camera frame carrying the steering
// error and path features; result stream (out_*): the clamped steering
// offset and the proportional gain chosen for that request.
// Configuration is written through cfg_we / cfg_addr / cfg_wdata while the
// block is idle; the user must keep to this, the block does not enforce it.
// Writes take effect at once and there is no read-back.
// Each request runs through one shared 18x18 signed multiplier under a small
// sequencer: square of the row difference, reciprocal divide, gain forming,
// gain times error, derivative gain times error change, then accumulate and
// clamp, one sequencer step each.
// in_tready is high only while the sequencer is idle. A finished result
// waits in the output register; the next request may be accepted meanwhile,
// but it holds in its clamp step until the output register is free.
// Synchronous active-low reset clears the sequencer, the output valid, the
// previous error and loads the register defaults.
`include "gain_scheduled_steering_pd_defines.svh"

module gain_scheduled_steering_pd
  import gssp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // Configuration write port
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata,
  // Request channel
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [31:0]         in_tdata,  // error[8:0], visible_lines[16:9],
                                         // corner_count[20:17], straight_run[28:21]
  input  logic [1:0]          in_tuser,  // straight_flag[0], cross_flag[1]
  // Result channel
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [31:0]         out_tdata  // steer[14:0], gain_used[31:15]
);

  typedef enum logic [2:0] {
    S_IDLE, S_SQ, S_DIV, S_GAIN, S_PMUL, S_DMUL, S_ACC, S_CLAMP
  } state_t;

  state_t state_r;

  // Configuration registers
  logic                       seg_mode_r;
  logic signed [OffW-1:0]     gain_off_r;
  logic [DGainW-1:0]          dgain_r;
  logic [HeightW-1:0]         height_r;
  logic signed [SteerW-1:0]   left_r;
  logic signed [SteerW-1:0]   right_r;

  // Request registers
  logic signed [ErrW-1:0]     err_r;
  logic [VisW-1:0]            vis_r;
  logic [CornW-1:0]           corn_r;
  logic                       straight_r;
  logic                       cross_r;
  logic [RunW-1:0]            run_r;

  logic signed [ErrW-1:0]     prev_err_r;
  logic signed [ProdW-1:0]    prod_r;
  logic signed [AccW-1:0]     acc_r;
  logic [GainW-1:0]           gain_r;
  logic                       out_valid_r;
  logic signed [SteerW-1:0]   out_steer_r;
  logic [GainW-1:0]           out_gain_r;

  logic                       in_acc;
  logic                       out_free;
  logic signed [ErrW-1:0]     diff_h;
  logic signed [ErrW:0]       err_chg;
  logic signed [MulW-1:0]     mul_a;
  logic signed [MulW-1:0]     mul_b;
  logic signed [ProdW-1:0]    mul_p;
  logic [12:0]                quot;
  logic [9:0]                 base16;
  logic signed [18:0]         gain_sum;
  logic [GainW-1:0]           gain_nxt;
  logic signed [AccW-1:0]     acc_rnd;
  logic signed [StW-1:0]      st_div;
  logic signed [StW-1:0]      st_left;
  logic signed [StW-1:0]      st_clamp;
  logic signed [StW-1:0]      left_ext;
  logic signed [StW-1:0]      right_ext;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_gain_r, out_steer_r};

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_mode_r <= 1'b1;
      gain_off_r <= '0;
      dgain_r    <= '0;
      height_r   <= HEIGHT_RST;
      left_r     <= LEFT_RST;
      right_r    <= RIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_SEG_MODE:    seg_mode_r <= cfg_wdata[0];
        CFG_GAIN_OFFSET: gain_off_r <= cfg_wdata[OffW-1:0];
        CFG_DERIV_GAIN:  dgain_r    <= cfg_wdata[DGainW-1:0];
        CFG_IMG_HEIGHT:  height_r   <= cfg_wdata[HeightW-1:0];
        CFG_LEFT_LIMIT:  left_r     <= cfg_wdata[SteerW-1:0];
        CFG_RIGHT_LIMIT: right_r    <= cfg_wdata[SteerW-1:0];
        default: ;
      endcase
    end
  end

  // Select operands of the shared multiplier by sequencer step
  assign diff_h  = $signed({1'b0, height_r}) - $signed({1'b0, vis_r});
  assign err_chg = $signed({err_r[ErrW-1], err_r}) -
                   $signed({prev_err_r[ErrW-1], prev_err_r});

  always_comb begin
    case (state_r)
      S_SQ: begin
        mul_a = MulW'(diff_h);
        mul_b = MulW'(diff_h);
      end
      S_DIV: begin
        mul_a = $signed({2'b00, prod_r[15:0]});
        mul_b = $signed({2'b00, (seg_mode_r ? RECIP_10 : RECIP_12)});
      end
      S_PMUL: begin
        mul_a = $signed({1'b0, gain_r});
        mul_b = MulW'(err_r);
      end
      S_DMUL: begin
        mul_a = $signed({{(MulW-DGainW){1'b0}}, dgain_r});
        mul_b = MulW'(err_chg);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Form the proportional gain and saturate it to its range
  assign quot   = prod_r[RecipShift+12:RecipShift];
  assign base16 = seg_mode_r ? seg_base(vis_r, corn_r, straight_r, cross_r, run_r)
                             : fix_base(vis_r, corn_r, cross_r);
  assign gain_sum = $signed({9'd0, base16}) + $signed({2'b00, quot, 4'b0000}) +
                    (seg_mode_r ? 19'(gain_off_r) : 19'sd0);

  always_comb begin
    if (gain_sum < 0)                          gain_nxt = '0;
    else if (gain_sum > $signed({2'b00, GAIN_MAX})) gain_nxt = GAIN_MAX;
    else                                       gain_nxt = gain_sum[GainW-1:0];
  end

  // Divide by 16 toward zero, then clamp left first and right last
  assign acc_rnd   = acc_r + (acc_r[AccW-1] ? AccW'(15) : AccW'(0));
  assign st_div    = StW'(acc_rnd >>> 4);
  assign left_ext  = StW'(left_r);
  assign right_ext = StW'(right_r);
  assign st_left   = (st_div > left_ext) ? left_ext : st_div;
  assign st_clamp  = (st_left < right_ext) ? right_ext : st_left;

  // Sequencer, datapath registers and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      prev_err_r  <= '0;
    end else begin
      // Drop the output valid once taken, unless the clamp step reloads it
      if (out_valid_r && out_tready && state_r != S_CLAMP) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            err_r      <= in_tdata[8:0];
            vis_r      <= in_tdata[16:9];
            corn_r     <= in_tdata[20:17];
            run_r      <= in_tdata[28:21];
            straight_r <= in_tuser[0];
            cross_r    <= in_tuser[1];
            state_r    <= S_SQ;
          end
        end
        S_SQ: begin
          prod_r  <= mul_p;
          state_r <= S_DIV;
        end
        S_DIV: begin
          prod_r  <= mul_p;
          state_r <= S_GAIN;
        end
        S_GAIN: begin
          gain_r  <= gain_nxt;
          state_r <= S_PMUL;
        end
        S_PMUL: begin
          prod_r  <= mul_p;
          state_r <= S_DMUL;
        end
        S_DMUL: begin
          acc_r   <= prod_r[AccW-1:0];
          prod_r  <= mul_p;
          state_r <= S_ACC;
        end
        S_ACC: begin
          acc_r   <= acc_r + prod_r[AccW-1:0];
          state_r <= S_CLAMP;
        end
        S_CLAMP: begin
          // Hold until the output register is free
          if (out_free) begin
            out_steer_r <= st_clamp[SteerW-1:0];
            out_gain_r  <= gain_r;
            out_valid_r <= 1'b1;
            prev_err_r  <= err_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `GSSP_ASSERT(a_busy_after_req, in_acc |=> !in_tready, "ready stayed high after a request")
  `GSSP_ASSERT(a_clamp_loads_out,
    (state_r == S_CLAMP && out_free) |=> (out_valid_r && state_r == S_IDLE),
    "finished result not loaded into the output register")
  `GSSP_ASSERT(a_prev_err_kept,
    (state_r == S_CLAMP && out_free) |=> (prev_err_r == $past(err_r)),
    "previous error not updated on completion")
  `GSSP_ASSERT(a_no_overwrite,
    (state_r == S_CLAMP && !out_free) |=> (state_r == S_CLAMP),
    "sequencer left the clamp step while the output was stalled")

endmodule
